### hw/rtl/rdq_pkg.sv
`default_nettype none
package rdq_pkg;

   localparam int CAPACITY    = 256;
   localparam int HANDLE_BITS = 32;
   localparam int PTR_BITS    = $clog2(CAPACITY);
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
   localparam int OFFSET_BITS = 8;
   localparam int WIDE_BITS   = ((COUNT_BITS > OFFSET_BITS) ? COUNT_BITS : OFFSET_BITS) + 1;
   localparam int OCC_BITS    = 9;
   localparam int FIELD_BITS  = 32;

   typedef enum logic [1:0] {
      KIND_PUSH_BACK  = 2'd0,
      KIND_PUSH_FRONT = 2'd1,
      KIND_PEEK       = 2'd2,
      KIND_REMOVE     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

endpackage
`default_nettype wire

### hw/rtl/rdq_channels.sv
`default_nettype none
interface rdq_req_if;
   logic                                valid;
   logic                                ready;
   rdq_pkg::kind_type                   kind;
   logic [rdq_pkg::FIELD_BITS-1:0]      handle;
   logic [rdq_pkg::OFFSET_BITS-1:0]     offset;
   logic                                batch_last;

   modport source (output valid, kind, handle, offset, batch_last, input ready);
   modport sink   (input valid, kind, handle, offset, batch_last, output ready);
endinterface

interface rdq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rdq_pkg::FIELD_BITS-1:0]      handle_out;
   rdq_pkg::status_type                 status;
   logic [rdq_pkg::OCC_BITS-1:0]        occupancy;

   modport source (output valid, handle_out, status, occupancy, input ready);
   modport sink   (input valid, handle_out, status, occupancy, output ready);
endinterface
`default_nettype wire

### hw/rtl/rdq_ram.sv
`default_nettype none
module rdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule
`default_nettype wire

### hw/rtl/ring_deque_with_offset_removal_top.sv
// Fixed-capacity circular deque of task handles held in one synchronous RAM with
// two read ports. Each request transaction (push back, push front, peek, remove
// at offset) gives exactly one response transaction carrying the handle found,
// a status (ok, full, offset out of range) and the occupancy after the operation.
// Pushes and out-of-range or refused operations answer straight from the idle state;
// a valid peek or remove goes through the read state for the registered read of the
// slot RAM (remove writes the head entry back into the removed slot in that state).
// A finished response waits in an output register and a new request is taken in
// the same cycle that response is taken. No clearing pass after reset: slots are
// only read below the occupancy.
`default_nettype none
module ring_deque_with_offset_removal_top (
   input wire logic  clock,
   input wire logic  reset,
   rdq_req_if.sink   req_ch,
   rdq_rsp_if.source rsp_ch
);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   localparam logic [rdq_pkg::WIDE_BITS-1:0] CAP_W = rdq_pkg::WIDE_BITS'(rdq_pkg::CAPACITY);
   localparam logic [rdq_pkg::PTR_BITS-1:0]  LAST_SLOT =
      rdq_pkg::PTR_BITS'(rdq_pkg::CAPACITY - 1);

   state_type                           state_ff, state_in;
   logic [rdq_pkg::PTR_BITS-1:0]        head_ff, head_in;
   logic [rdq_pkg::COUNT_BITS-1:0]      count_ff, count_in;
   logic [rdq_pkg::PTR_BITS-1:0]        pos_ff, pos_in;
   logic                                remove_ff, remove_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rdq_pkg::FIELD_BITS-1:0]      rsp_handle_ff, rsp_handle_in;
   rdq_pkg::status_type                 rsp_status_ff, rsp_status_in;
   logic [rdq_pkg::OCC_BITS-1:0]        rsp_occ_ff, rsp_occ_in;

   logic                                accept;
   logic [rdq_pkg::WIDE_BITS-1:0]       offset_w, count_w, pos_sum, tail_sum;
   logic [rdq_pkg::PTR_BITS-1:0]        pos_slot, tail_slot, front_slot;
   logic                                wr_en;
   logic [rdq_pkg::PTR_BITS-1:0]        wr_addr;
   logic [rdq_pkg::HANDLE_BITS-1:0]     wr_data;
   logic [rdq_pkg::HANDLE_BITS-1:0]     rd_data_a, rd_data_b;

   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.handle_out = rsp_handle_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.occupancy  = rsp_occ_ff;

   // slot arithmetic, sums stay below twice the capacity
   assign offset_w   = rdq_pkg::WIDE_BITS'(req_ch.offset);
   assign count_w    = rdq_pkg::WIDE_BITS'(count_ff);
   assign pos_sum    = rdq_pkg::WIDE_BITS'(head_ff) + offset_w;
   assign tail_sum   = rdq_pkg::WIDE_BITS'(head_ff) + count_w;
   assign pos_slot   = (pos_sum >= CAP_W) ? rdq_pkg::PTR_BITS'(pos_sum - CAP_W)
                                          : rdq_pkg::PTR_BITS'(pos_sum);
   assign tail_slot  = (tail_sum >= CAP_W) ? rdq_pkg::PTR_BITS'(tail_sum - CAP_W)
                                           : rdq_pkg::PTR_BITS'(tail_sum);
   assign front_slot = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;

   rdq_ram #(
      .WIDTH(rdq_pkg::HANDLE_BITS),
      .DEPTH(rdq_pkg::CAPACITY)
   ) u_slots (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (pos_slot),
      .rd_data_a (rd_data_a),
      .rd_addr_b (head_ff),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      remove_in     = remove_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_slot;
      wr_data       = rdq_pkg::HANDLE_BITS'(req_ch.handle);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_handle_in = '0;
               rsp_status_in = rdq_pkg::STATUS_OK;
               case (req_ch.kind)
                  rdq_pkg::KIND_PUSH_BACK, rdq_pkg::KIND_PUSH_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (count_w >= CAP_W) begin
                        rsp_status_in = rdq_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        if (req_ch.kind == rdq_pkg::KIND_PUSH_FRONT) begin
                           wr_addr = front_slot;
                           head_in = front_slot;
                        end
                     end
                  end
                  default: begin
                     if (offset_w >= count_w) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = rdq_pkg::STATUS_RANGE;
                     end else begin
                        state_in  = S_READ;
                        pos_in    = pos_slot;
                        remove_in = (req_ch.kind == rdq_pkg::KIND_REMOVE);
                     end
                  end
               endcase
               rsp_occ_in = rdq_pkg::OCC_BITS'(count_in);
            end
         end
         S_READ: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_handle_in = rdq_pkg::FIELD_BITS'(rd_data_a);
            rsp_status_in = rdq_pkg::STATUS_OK;
            if (remove_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = rd_data_b;
               head_in  = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end
            rsp_occ_in = rdq_pkg::OCC_BITS'(count_in);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         remove_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         remove_ff    <= remove_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

endmodule
`default_nettype wire

### hw/rtl/rdq_checker.sv
`default_nettype none
module rdq_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [1:0]                         rsp_status,
   input wire logic [rdq_pkg::OCC_BITS-1:0]       rsp_occupancy
);

   localparam logic [rdq_pkg::OCC_BITS-1:0] CAP_OCC = rdq_pkg::OCC_BITS'(rdq_pkg::CAPACITY);

   // a pending response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before taken");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= CAP_OCC)
      else $error("occupancy above capacity");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rdq_pkg::STATUS_FULL |-> rsp_occupancy == CAP_OCC)
      else $error("full status without full occupancy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == rdq_pkg::STATUS_OK || rsp_status == rdq_pkg::STATUS_FULL
                    || rsp_status == rdq_pkg::STATUS_RANGE)
      else $error("undefined status code");

   // no response is valid right after reset
   a_no_spurious: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

endmodule

bind ring_deque_with_offset_removal_top rdq_checker u_rdq_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_occupancy (rsp_ch.occupancy)
);
`default_nettype wire

### bench/ring_deque_with_offset_removal_top_test.sv
`timescale 1ns / 100ps

typedef struct {
   logic [rdq_pkg::FIELD_BITS-1:0] handle_out;
   rdq_pkg::status_type            status;
   logic [rdq_pkg::OCC_BITS-1:0]   occupancy;
} deque_rsp_type;

class deque_shadow;
   logic [rdq_pkg::HANDLE_BITS-1:0] slots [rdq_pkg::CAPACITY];
   int                              head;
   int                              count;
   deque_rsp_type                   pending_results [$];
   int                              mismatches;
   int                              kind_counts [4];
   int                              full_refusals;
   int                              range_misses;
   int                              peak_count;
   int                              checked;

   function new();
      head          = 0;
      count         = 0;
      mismatches    = 0;
      full_refusals = 0;
      range_misses  = 0;
      peak_count    = 0;
      checked       = 0;
      foreach (kind_counts[i]) kind_counts[i] = 0;
   endfunction

   function int pending();
      return pending_results.size();
   endfunction

   // accepted request transaction: advance the deque state, queue the response
   function void note_request(rdq_pkg::kind_type kind, logic [rdq_pkg::FIELD_BITS-1:0] handle,
                              logic [rdq_pkg::OFFSET_BITS-1:0] offset);
      deque_rsp_type want;
      int            slot;
      want.handle_out = '0;
      want.status     = rdq_pkg::STATUS_OK;
      kind_counts[int'(kind)]++;
      case (kind)
         rdq_pkg::KIND_PUSH_BACK, rdq_pkg::KIND_PUSH_FRONT: begin
            if (count >= rdq_pkg::CAPACITY) begin
               want.status = rdq_pkg::STATUS_FULL;
               full_refusals++;
            end else if (kind == rdq_pkg::KIND_PUSH_BACK) begin
               slots[(head + count) % rdq_pkg::CAPACITY] = handle;
               count++;
            end else begin
               head        = (head + rdq_pkg::CAPACITY - 1) % rdq_pkg::CAPACITY;
               slots[head] = handle;
               count++;
            end
         end
         default: begin
            if (int'(offset) >= count) begin
               want.status = rdq_pkg::STATUS_RANGE;
               range_misses++;
            end else begin
               slot            = (head + int'(offset)) % rdq_pkg::CAPACITY;
               want.handle_out = slots[slot];
               if (kind == rdq_pkg::KIND_REMOVE) begin
                  slots[slot] = slots[head];
                  head        = (head + 1) % rdq_pkg::CAPACITY;
                  count--;
               end
            end
         end
      endcase
      want.occupancy = rdq_pkg::OCC_BITS'(count);
      if (count > peak_count) peak_count = count;
      pending_results.push_back(want);
   endfunction

   function void check_response(logic [rdq_pkg::FIELD_BITS-1:0] handle_out,
                                rdq_pkg::status_type status,
                                logic [rdq_pkg::OCC_BITS-1:0] occupancy);
      deque_rsp_type want;
      checked++;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: response with nothing expected: handle %h status %0d occupancy %0d",
                     $time, handle_out, status, occupancy);
         return;
      end
      want = pending_results.pop_front();
      if (handle_out !== want.handle_out || status !== want.status
          || occupancy !== want.occupancy) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch: handle %h/%h status %0d/%0d occupancy %0d/%0d (exp/act)",
                     $time, want.handle_out, handle_out, want.status, status,
                     want.occupancy, occupancy);
      end
   endfunction

   function void flag_leftovers();
      if (pending_results.size() != 0) begin
         mismatches += pending_results.size();
         $display("%0d expected responses never arrived", pending_results.size());
      end
   endfunction
endclass

module ring_deque_with_offset_removal_top_test;

   logic        clock;
   logic        reset;
   int          req_idle_pct;
   int          rsp_idle_pct;
   deque_shadow shadow;

   rdq_req_if req_ch();
   rdq_rsp_if rsp_ch();

   ring_deque_with_offset_removal_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      #2_000_000;
      $display("ring_deque_with_offset_removal_top verification failed");
      $finish;
   end

   // response side: check accepted transactions, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         shadow.check_response(rsp_ch.handle_out, rsp_ch.status, rsp_ch.occupancy);
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   task automatic send_op(rdq_pkg::kind_type kind, logic [rdq_pkg::FIELD_BITS-1:0] handle,
                          logic [rdq_pkg::OFFSET_BITS-1:0] offset, logic last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.handle     <= handle;
      req_ch.offset     <= offset;
      req_ch.batch_last <= last;
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
      shadow.note_request(kind, handle, offset);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (shadow.pending() > 0)
         @(posedge clock);
   endtask

   task automatic run_random(int n_items, bit fill_first);
      int                              sent;
      int                              burst_left;
      int                              push_pct;
      int                              roll;
      rdq_pkg::kind_type               kind;
      logic [rdq_pkg::FIELD_BITS-1:0]  handle;
      logic [rdq_pkg::OFFSET_BITS-1:0] offset;
      sent       = 0;
      burst_left = 0;
      push_pct   = 50;
      if (fill_first) begin
         burst_left = 320;
         push_pct   = 95;
      end
      while (sent < n_items) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(8, 96);
            case ($urandom_range(0, 2))
               0:       push_pct = 85;
               1:       push_pct = 15;
               default: push_pct = 50;
            endcase
         end
         if ($urandom_range(0, 99) < push_pct)
            kind = $urandom_range(0, 1) ? rdq_pkg::KIND_PUSH_BACK : rdq_pkg::KIND_PUSH_FRONT;
         else
            kind = $urandom_range(0, 1) ? rdq_pkg::KIND_PEEK : rdq_pkg::KIND_REMOVE;
         roll = $urandom_range(0, 19);
         if (roll == 0)
            handle = '0;
         else if (roll == 1)
            handle = '1;
         else
            handle = $urandom();
         roll = $urandom_range(0, 99);
         if (shadow.count > 0 && roll < 70)
            offset = rdq_pkg::OFFSET_BITS'($urandom_range(0, shadow.count - 1));
         else if (roll < 85)
            offset = rdq_pkg::OFFSET_BITS'(shadow.count);
         else
            offset = rdq_pkg::OFFSET_BITS'($urandom_range(0, 255));
         send_op(kind, handle, offset, $urandom_range(0, 3) == 0);
         sent++;
         burst_left--;
      end
   endtask

   initial begin
      int waited;
      shadow            = new();
      reset             = 1'b1;
      req_idle_pct      = 0;
      rsp_idle_pct      = 0;
      req_ch.valid      = 1'b0;
      req_ch.kind       = rdq_pkg::KIND_PUSH_BACK;
      req_ch.handle     = '0;
      req_ch.offset     = '0;
      req_ch.batch_last = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty deque, extremes, head wrap via push front, removal cases
      send_op(rdq_pkg::KIND_PEEK, 32'hFFFF_FFFF, 8'd0, 1'b0);
      send_op(rdq_pkg::KIND_REMOVE, 32'h0, 8'd255, 1'b1);
      send_op(rdq_pkg::KIND_PUSH_BACK, 32'h0000_0000, 8'hFF, 1'b0);
      send_op(rdq_pkg::KIND_PUSH_BACK, 32'hFFFF_FFFF, 8'h00, 1'b1);
      send_op(rdq_pkg::KIND_PUSH_FRONT, 32'hA5A5_5A5A, 8'h55, 1'b0);
      send_op(rdq_pkg::KIND_PUSH_FRONT, 32'h5A5A_A5A5, 8'hAA, 1'b1);
      send_op(rdq_pkg::KIND_PEEK, 32'h0, 8'd0, 1'b0);
      send_op(rdq_pkg::KIND_PEEK, 32'h0, 8'd3, 1'b0);
      send_op(rdq_pkg::KIND_PEEK, 32'h0, 8'd4, 1'b0);
      send_op(rdq_pkg::KIND_PEEK, 32'hFFFF_FFFF, 8'd255, 1'b1);
      send_op(rdq_pkg::KIND_REMOVE, 32'h0, 8'd2, 1'b0);
      send_op(rdq_pkg::KIND_REMOVE, 32'h0, 8'd0, 1'b0);
      send_op(rdq_pkg::KIND_REMOVE, 32'h0, 8'd1, 1'b0);
      send_op(rdq_pkg::KIND_PEEK, 32'h0, 8'd0, 1'b0);
      send_op(rdq_pkg::KIND_REMOVE, 32'h0, 8'd1, 1'b0);
      send_op(rdq_pkg::KIND_REMOVE, 32'h0, 8'd0, 1'b0);
      send_op(rdq_pkg::KIND_REMOVE, 32'h0, 8'd0, 1'b1);
      wait_drained();

      req_idle_pct = 29;
      rsp_idle_pct = 52;
      run_random(670, 1'b0);
      wait_drained();

      req_idle_pct = 52;
      rsp_idle_pct = 29;
      run_random(670, 1'b1);
      wait_drained();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(660, 1'b0);
      req_ch.valid <= 1'b0;

      waited = 0;
      while (shadow.pending() > 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      shadow.flag_leftovers();

      $display("ran %0d transactions: %0d push back, %0d push front, %0d peek, %0d remove",
               shadow.checked, shadow.kind_counts[0], shadow.kind_counts[1],
               shadow.kind_counts[2], shadow.kind_counts[3]);
      $display("refused pushes when full: %0d, offsets out of range: %0d, peak occupancy %0d",
               shadow.full_refusals, shadow.range_misses, shadow.peak_count);
      if (shadow.mismatches == 0)
         $display("ring_deque_with_offset_removal_top verification clean");
      else
         $display("ring_deque_with_offset_removal_top verification failed");
      $finish;
   end

endmodule

### sim.f
hw/rtl/rdq_pkg.sv
hw/rtl/rdq_channels.sv
hw/rtl/rdq_ram.sv
hw/rtl/ring_deque_with_offset_removal_top.sv
hw/rtl/rdq_checker.sv
bench/ring_deque_with_offset_removal_top_test.sv
